// ----- sv/pvlv_pkg.sv -----
// Package for the partial-volume label vote block.
// Holds the beat structs, the corner count and the pipeline depth.
// No dependencies.
`timescale 1ns / 1ps

package pvlv_pkg;

  localparam int CORNERS      = 8;
  localparam int FIELD_W      = 16;
  localparam int MASK_W       = 8;
  localparam int LABEL_BITS_D = 16;
  localparam int FRAC_BITS_D  = 16;
  localparam int PIPE_DEPTH   = 9;

  typedef struct packed {
    logic [FIELD_W-1:0] corner_0;
    logic [FIELD_W-1:0] corner_1;
    logic [FIELD_W-1:0] corner_2;
    logic [FIELD_W-1:0] corner_3;
    logic [FIELD_W-1:0] corner_4;
    logic [FIELD_W-1:0] corner_5;
    logic [FIELD_W-1:0] corner_6;
    logic [FIELD_W-1:0] corner_7;
    logic [MASK_W-1:0]  valid_mask;
    logic [FIELD_W-1:0] frac_x;
    logic [FIELD_W-1:0] frac_y;
    logic [FIELD_W-1:0] frac_z;
  } pvlv_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] label_out;
    logic               any_valid;
  } pvlv_out_t;

endpackage

// ----- sv/pvlv_weight_lane.sv -----
// One weight lane: forms the trilinear weight of one corner in two
// registered multiplications. Depends on nothing but its parameters.
`timescale 1ns / 1ps

module pvlv_weight_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic [FRAC_BITS:0]   fa,
  input  logic [FRAC_BITS:0]   fb,
  input  logic [FRAC_BITS:0]   fc,
  output logic [3*FRAC_BITS:0] weight
);

  localparam int F1 = FRAC_BITS + 1;
  localparam int XW = 2 * F1;
  localparam int PW = 3 * F1;
  localparam int WW = 3 * FRAC_BITS + 1;

  logic [XW-1:0] xy_r;
  logic [F1-1:0] fc_r;
  logic [PW-1:0] prod;
  logic [WW-1:0] w_r;

  assign prod   = xy_r * fc_r;
  assign weight = w_r;

  always_ff @(posedge clk) begin
    xy_r <= fa * fb;
    fc_r <= fc;
    w_r  <= prod[WW-1:0];
  end

endmodule

// ----- sv/pvlv_group_lane.sv -----
// One grouping lane: sums the weights of all valid corners whose label
// equals this lane's label, through a three-level registered adder tree.
// Depends on pvlv_pkg.
`timescale 1ns / 1ps

module pvlv_group_lane #(
  parameter int WEIGHT_W = 49,
  parameter int LABEL_W  = 16
) (
  input  logic                       clk,
  input  logic [LABEL_W-1:0]         own_lab,
  input  logic                       own_vld,
  input  logic [LABEL_W-1:0]         lab_all [pvlv_pkg::CORNERS],
  input  logic [pvlv_pkg::MASK_W-1:0] vmask,
  input  logic [WEIGHT_W-1:0]        w_all   [pvlv_pkg::CORNERS],
  output logic [WEIGHT_W-1:0]        sum_out,
  output logic [LABEL_W-1:0]         lab_out
);

  import pvlv_pkg::*;

  localparam int HALF    = CORNERS / 2;
  localparam int QUARTER = CORNERS / 4;

  logic [WEIGHT_W-1:0] term   [CORNERS];
  logic [WEIGHT_W-1:0] s1_nxt [HALF];
  logic [WEIGHT_W-1:0] s1_r   [HALF];
  logic [WEIGHT_W-1:0] s2_r   [QUARTER];
  logic [WEIGHT_W-1:0] sum_r;
  logic [LABEL_W-1:0]  lab1_r;
  logic [LABEL_W-1:0]  lab2_r;
  logic [LABEL_W-1:0]  lab3_r;

  // A lane whose own corner is invalid reports nothing, so a group always
  // shows up first at the lane of its lowest valid corner.
  always_comb begin
    for (int m = 0; m < CORNERS; m++) begin
      term[m] = (own_vld && vmask[m] && (lab_all[m] == own_lab)) ? w_all[m] : '0;
    end
    for (int k = 0; k < HALF; k++) begin
      s1_nxt[k] = term[2*k] + term[2*k+1];
    end
  end

  always_ff @(posedge clk) begin
    s1_r   <= s1_nxt;
    lab1_r <= own_lab;
    for (int k = 0; k < QUARTER; k++) begin
      s2_r[k] <= s1_r[2*k] + s1_r[2*k+1];
    end
    lab2_r <= lab1_r;
    sum_r  <= s2_r[0] + s2_r[1];
    lab3_r <= lab2_r;
  end

  assign sum_out = sum_r;
  assign lab_out = lab3_r;

endmodule

// ----- sv/pvlv_merge.sv -----
// Merging stage: picks the lane with the greatest group weight over a
// three-level registered compare tree, the lower corner winning ties.
// Depends on pvlv_pkg.
`timescale 1ns / 1ps

module pvlv_merge #(
  parameter int WEIGHT_W = 49,
  parameter int LABEL_W  = 16
) (
  input  logic                       clk,
  input  logic [WEIGHT_W-1:0]        sum_in [pvlv_pkg::CORNERS],
  input  logic [LABEL_W-1:0]         lab_in [pvlv_pkg::CORNERS],
  input  logic                       any_valid_in,
  output pvlv_pkg::pvlv_out_t        result
);

  import pvlv_pkg::*;

  localparam int HALF    = CORNERS / 2;
  localparam int QUARTER = CORNERS / 4;

  logic [WEIGHT_W-1:0] m1_sum_r [HALF];
  logic [LABEL_W-1:0]  m1_lab_r [HALF];
  logic [WEIGHT_W-1:0] m2_sum_r [QUARTER];
  logic [LABEL_W-1:0]  m2_lab_r [QUARTER];
  logic                av1_r;
  logic                av2_r;
  logic [WEIGHT_W-1:0] best_sum;
  logic [LABEL_W-1:0]  best_lab;
  pvlv_out_t           result_nxt;
  pvlv_out_t           result_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < HALF; k++) begin
      if (sum_in[2*k] >= sum_in[2*k+1]) begin
        m1_sum_r[k] <= sum_in[2*k];
        m1_lab_r[k] <= lab_in[2*k];
      end else begin
        m1_sum_r[k] <= sum_in[2*k+1];
        m1_lab_r[k] <= lab_in[2*k+1];
      end
    end
    av1_r <= any_valid_in;
    for (int k = 0; k < QUARTER; k++) begin
      if (m1_sum_r[2*k] >= m1_sum_r[2*k+1]) begin
        m2_sum_r[k] <= m1_sum_r[2*k];
        m2_lab_r[k] <= m1_lab_r[2*k];
      end else begin
        m2_sum_r[k] <= m1_sum_r[2*k+1];
        m2_lab_r[k] <= m1_lab_r[2*k+1];
      end
    end
    av2_r    <= av1_r;
    result_r <= result_nxt;
  end

  always_comb begin
    if (m2_sum_r[0] >= m2_sum_r[1]) begin
      best_sum = m2_sum_r[0];
      best_lab = m2_lab_r[0];
    end else begin
      best_sum = m2_sum_r[1];
      best_lab = m2_lab_r[1];
    end
    result_nxt.label_out = (best_sum != '0) ? FIELD_W'(best_lab) : '0;
    result_nxt.any_valid = av2_r;
  end

  assign result = result_r;

endmodule

// ----- sv/partial_volume_label_vote.sv -----
// Partial-volume label vote: eight weight lanes, eight grouping lanes and
// a merging tree in a nine-stage pipeline. A beat's strobe runs down a shift
// register beside it, so out_valid is high for one cycle, the cycle in which
// the result of that beat sits in the output register.
// One beat is taken every cycle; busy stays low, as the pipeline never stalls.
// The throughput is set by the fully pipelined multiplier and adder lanes.
// Reset clears only the strobe pipeline; results in flight are dropped.
`timescale 1ns / 1ps

module partial_volume_label_vote #(
  parameter int LABEL_BITS = pvlv_pkg::LABEL_BITS_D,
  parameter int FRAC_BITS  = pvlv_pkg::FRAC_BITS_D
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pvlv_pkg::pvlv_in_t  in_item,
  output logic                out_valid,
  output pvlv_pkg::pvlv_out_t out_item
);

  import pvlv_pkg::*;

  localparam int LW = (LABEL_BITS < FIELD_W) ? LABEL_BITS : FIELD_W;
  localparam int FW = (FRAC_BITS < FIELD_W) ? FRAC_BITS : FIELD_W;
  localparam int F1 = FRAC_BITS + 1;
  localparam int WW = 3 * FRAC_BITS + 1;

  logic [FIELD_W-1:0]   corner   [CORNERS];
  logic [F1-1:0]        one_frac;
  logic [F1-1:0]        hi_nxt   [3];
  logic [F1-1:0]        hi_r     [3];
  logic [F1-1:0]        lo_r     [3];
  logic [LW-1:0]        lab1_r   [CORNERS];
  logic [LW-1:0]        lab2_r   [CORNERS];
  logic [LW-1:0]        lab3_r   [CORNERS];
  logic [MASK_W-1:0]    vm1_r;
  logic [MASK_W-1:0]    vm2_r;
  logic [MASK_W-1:0]    vm3_r;
  logic [WW-1:0]        weight   [CORNERS];
  logic [WW-1:0]        gsum     [CORNERS];
  logic [LW-1:0]        glab     [CORNERS];
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-4:0] av_r;
  logic                 accept;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign one_frac = F1'(1) << FRAC_BITS;

  always_comb begin
    corner[0] = in_item.corner_0;
    corner[1] = in_item.corner_1;
    corner[2] = in_item.corner_2;
    corner[3] = in_item.corner_3;
    corner[4] = in_item.corner_4;
    corner[5] = in_item.corner_5;
    corner[6] = in_item.corner_6;
    corner[7] = in_item.corner_7;
    hi_nxt[0] = F1'(in_item.frac_x[FW-1:0]);
    hi_nxt[1] = F1'(in_item.frac_y[FW-1:0]);
    hi_nxt[2] = F1'(in_item.frac_z[FW-1:0]);
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      hi_r[a] <= hi_nxt[a];
      lo_r[a] <= one_frac - hi_nxt[a];
    end
    for (int n = 0; n < CORNERS; n++) begin
      lab1_r[n] <= corner[n][LW-1:0];
    end
    lab2_r <= lab1_r;
    lab3_r <= lab2_r;
    vm1_r  <= in_item.valid_mask;
    vm2_r  <= vm1_r;
    vm3_r  <= vm2_r;
    av_r   <= {av_r[PIPE_DEPTH-5:0], (in_item.valid_mask != '0)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], accept};
    end
  end

  for (genvar n = 0; n < CORNERS; n++) begin : g_lane
    pvlv_weight_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_weight (
      .clk    (clk),
      .fa     (((n % 2) != 0)       ? hi_r[0] : lo_r[0]),
      .fb     ((((n / 2) % 2) != 0) ? hi_r[1] : lo_r[1]),
      .fc     ((((n / 4) % 2) != 0) ? hi_r[2] : lo_r[2]),
      .weight (weight[n])
    );

    pvlv_group_lane #(
      .WEIGHT_W (WW),
      .LABEL_W  (LW)
    ) u_group (
      .clk     (clk),
      .own_lab (lab3_r[n]),
      .own_vld (vm3_r[n]),
      .lab_all (lab3_r),
      .vmask   (vm3_r),
      .w_all   (weight),
      .sum_out (gsum[n]),
      .lab_out (glab[n])
    );
  end

  pvlv_merge #(
    .WEIGHT_W (WW),
    .LABEL_W  (LW)
  ) u_merge (
    .clk          (clk),
    .sum_in       (gsum),
    .lab_in       (glab),
    .any_valid_in (av_r[PIPE_DEPTH-4]),
    .result       (out_item)
  );

  assign out_valid = vld_r[PIPE_DEPTH-1];

endmodule
